// ===== sv/serial_velocity_frame_receiver_unit_defines.svh =====
// Assertion macros shared by the serial velocity frame receiver checkers.
// Depends on nothing; included by svfr_checker.sv.
`ifndef SERIAL_VELOCITY_FRAME_RECEIVER_UNIT_DEFINES_SVH
`define SERIAL_VELOCITY_FRAME_RECEIVER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SVFR_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SVFR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/svfr_pkg.sv =====
// Package for the serial velocity frame receiver: frame bytes, commands and sizes.
// Depends on nothing.
package svfr_pkg;

    localparam int PAYLOAD_BYTES = 5;
    localparam int CNT_W         = $clog2(PAYLOAD_BYTES + 1);
    localparam int IDX_W         = $clog2(PAYLOAD_BYTES);

    localparam logic [7:0] HDR_FIRST  = 8'h56;
    localparam logic [7:0] HDR_SECOND = 8'h91;
    localparam logic [7:0] TRAILER    = 8'h11;
    localparam logic [7:0] CMD_LEFT   = 8'hAA;
    localparam logic [7:0] CMD_RIGHT  = 8'hBB;
    localparam logic [7:0] CMD_REPORT = 8'hCC;

    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    typedef logic [7:0]  t_byte;
    typedef logic [31:0] t_word;

endpackage

// ===== sv/serial_velocity_frame_receiver_unit.sv =====
// Serial velocity frame receiver: input register, frame parser, result register.
// Path: an accepted beat is held in the input register, then moves into the result
// register once the result slot is free, raising o_valid; two register stages in all.
// Throughput: one beat per cycle while results drain; the parser advances once per beat.
// o_ready drops only while both stages hold a beat and i_ready is low (combinational).
// Reset: i_rst_n is synchronous, active low; it empties both stages, idles the parser,
// and zeroes both velocity words and the seen flag.
module serial_velocity_frame_receiver_unit
    import svfr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_kind,
    input  logic [7:0]  i_rx_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_left_velocity_bits,
    output logic [31:0] o_right_velocity_bits,
    output logic        o_send_request,
    output logic        o_frame_done
);

    // Parser phases.
    localparam logic [1:0] PH_IDLE    = 2'd0;
    localparam logic [1:0] PH_HDR     = 2'd1;
    localparam logic [1:0] PH_PAYLOAD = 2'd2;
    localparam logic [1:0] PH_TRAILER = 2'd3;

    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(PAYLOAD_BYTES);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

    // Input register stage.
    logic             r_in_valid;
    logic             r_in_kind;
    t_byte            r_in_byte;

    // Parser and velocity state.
    logic [1:0]       r_phase,  n_phase;
    logic [CNT_W-1:0] r_count,  n_count;
    t_byte            r_store [PAYLOAD_BYTES];
    t_byte            n_store [PAYLOAD_BYTES];
    t_word            r_left,   n_left;
    t_word            r_right,  n_right;
    logic             r_seen,   n_seen;

    // Result register stage.
    logic             r_out_valid;
    t_word            r_res_left;
    t_word            r_res_right;
    logic             r_res_send;
    logic             r_res_done;

    logic             n_send;
    logic             n_done;
    logic             out_free;
    logic             advance;
    logic [CNT_W-1:0] count_inc;
    t_word            payload_word;

    // The result slot is free when it is empty or being taken this cycle. The input
    // register moves into it whenever it holds a beat and the slot is free, so a new
    // beat can be taken every cycle while results keep draining.
    assign out_free = !r_out_valid || i_ready;
    assign advance  = r_in_valid && out_free;
    assign o_ready  = !r_in_valid || out_free;

    assign count_inc    = r_count + CNT_ONE;
    assign payload_word = {r_store[4], r_store[3], r_store[2], r_store[1]};

    // Parser for the beat held in the input register.
    always_comb begin
        n_phase = r_phase;
        n_count = r_count;
        n_store = r_store;
        n_left  = r_left;
        n_right = r_right;
        n_seen  = r_seen;
        n_send  = 1'b0;
        n_done  = 1'b0;

        priority if (r_in_kind == KIND_TICK) begin
            // A tick zeroes the targets unless a velocity frame came since the last one.
            if (!r_seen) begin
                n_left  = '0;
                n_right = '0;
            end else begin
                n_seen = 1'b0;
            end
        end else if (r_phase == PH_IDLE && r_in_byte == HDR_FIRST) begin
            n_phase = PH_HDR;
        end else if (r_phase == PH_HDR && r_in_byte == HDR_SECOND) begin
            n_phase = PH_PAYLOAD;
        end else if (r_phase == PH_PAYLOAD) begin
            // Every byte is payload here; the count decides when the trailer is due.
            if (r_count < CNT_FULL) begin
                for (int i = 0; i < PAYLOAD_BYTES; i++) begin
                    if (r_count[IDX_W-1:0] == IDX_W'(i)) begin
                        n_store[i] = r_in_byte;
                    end
                end
                n_count = count_inc;
                if (count_inc >= CNT_FULL) begin
                    n_phase = PH_TRAILER;
                end
            end else begin
                n_phase = PH_TRAILER;
            end
        end else if (r_phase == PH_TRAILER && r_in_byte == TRAILER) begin
            // Complete frame: the store keeps its bytes, the command byte decides.
            n_phase = PH_IDLE;
            n_count = '0;
            n_done  = 1'b1;
            priority if (r_store[0] == CMD_LEFT) begin
                n_left = payload_word;
                n_seen = 1'b1;
            end else if (r_store[0] == CMD_RIGHT) begin
                n_right = payload_word;
                n_seen  = 1'b1;
            end else if (r_store[0] == CMD_REPORT) begin
                n_send = 1'b1;
            end else begin
                // Unknown command: the frame counts as done and nothing else changes.
            end
        end else begin
            // Unexpected byte: back to idle with an empty store. A first header byte
            // that breaks a frame does not open a new one.
            n_phase = PH_IDLE;
            n_count = '0;
            for (int i = 0; i < PAYLOAD_BYTES; i++) begin
                n_store[i] = '0;
            end
        end
    end

    // Control state and the velocity words.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_phase     <= PH_IDLE;
            r_count     <= '0;
            r_left      <= '0;
            r_right     <= '0;
            r_seen      <= 1'b0;
            for (int i = 0; i < PAYLOAD_BYTES; i++) begin
                r_store[i] <= '0;
            end
        end else begin
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            if (out_free) begin
                r_out_valid <= r_in_valid;
            end
            if (advance) begin
                r_phase <= n_phase;
                r_count <= n_count;
                r_store <= n_store;
                r_left  <= n_left;
                r_right <= n_right;
                r_seen  <= n_seen;
            end
        end
    end

    // Payload registers of both stages.
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_kind <= i_kind;
            r_in_byte <= i_rx_byte;
        end
        if (advance) begin
            r_res_left  <= n_left;
            r_res_right <= n_right;
            r_res_send  <= n_send;
            r_res_done  <= n_done;
        end
    end

    assign o_valid               = r_out_valid;
    assign o_left_velocity_bits  = r_res_left;
    assign o_right_velocity_bits = r_res_right;
    assign o_send_request        = r_res_send;
    assign o_frame_done          = r_res_done;

endmodule

// ===== sv/svfr_checker.sv =====
// Port-level checker for the serial velocity frame receiver, bound to the top level.
// Depends on serial_velocity_frame_receiver_unit_defines.svh.
`include "serial_velocity_frame_receiver_unit_defines.svh"

module svfr_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_ready,
    input logic [31:0] o_left_velocity_bits,
    input logic [31:0] o_right_velocity_bits,
    input logic        o_send_request,
    input logic        o_frame_done
);

    // A stalled result beat keeps its payload.
    `SVFR_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_left_velocity_bits) && $stable(o_right_velocity_bits) && $stable(o_send_request) && $stable(o_frame_done), "result beat changed while stalled")

    // A send request only comes with a completed frame.
    `SVFR_ASSERT_SAME(a_send_in_frame, i_clk, i_rst_n, o_valid && o_send_request, o_frame_done, "send request without a completed frame")

    // A frame takes eight bytes, so two results in a row never both complete one.
    `SVFR_ASSERT_NEXT(a_done_spacing, i_clk, i_rst_n, o_valid && i_ready && o_frame_done, !(o_valid && o_frame_done), "frame completed on consecutive results")

endmodule

bind serial_velocity_frame_receiver_unit svfr_checker u_svfr_checker (.*);
